### src/ednh_pkg.sv
// Package for the escaped DNS name hash block.
// Types, character constants and the case-folding helper; no dependencies.
package ednh_pkg;

  localparam int unsigned LabelLimitDefault = 64;
  localparam int unsigned HashWidth = 32;
  localparam int unsigned DigitWidth = 10;
  localparam int unsigned LenWidth = 7;

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [DigitWidth-1:0] MaxByte = 10'd255;

  // Escape decode phase, one-hot.
  typedef enum logic [3:0] {
    PhNormal = 4'b0001,
    PhEsc    = 4'b0010,
    PhDig1   = 4'b0100,
    PhDig2   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrEscape = 2'd1,
    ErrLong   = 2'd2
  } err_e;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  // Fold A..Z to lowercase, then sign-extend as a signed char.
  function automatic logic [HashWidth-1:0] fold_char(logic [7:0] c);
    logic [7:0] v;
    v = c;
    if ((c >= CharUpperA) && (c <= CharUpperZ)) begin
      v = c + 8'd32;
    end
    return {{(HashWidth-8){v[7]}}, v};
  endfunction

endpackage

### src/escaped_dns_name_hash.sv
// Result: the hash and error code of a terminator word are registered (one register) at the edge that accepts it.
// Throughput: one word per cycle while in_ready_o is high; the hash update is a shift-subtract-add in one stage.
// The input is taken while a result waits whenever the result register is free or drained.
// Reset (rst_ni low, asynchronous): hash, escape phase, label length, error cleared; no result.
// Each terminator word also returns the decode state to its reset values.
// Top level of the escaped DNS name hash; depends on ednh_pkg.
module escaped_dns_name_hash
  import ednh_pkg::*;
#(
  parameter int unsigned LabelLimit = LabelLimitDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_code_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [HashWidth-1:0] name_hash_o,
  output logic [1:0]           error_code_o
);

  localparam logic [LenWidth-1:0] LimitLen = LenWidth'(LabelLimit);

  logic [HashWidth-1:0]  hash_q, hash_d;
  phase_e                phase_q, phase_d;
  logic [DigitWidth-1:0] digit_q, digit_d;
  logic [LenWidth-1:0]   len_q, len_d;
  err_e                  err_q, err_d;
  logic                  out_valid_q, out_valid_d;
  logic [HashWidth-1:0]  name_hash_q;
  logic [1:0]            error_code_q;

  logic                  accept;
  logic                  term;
  logic                  add_en;
  logic [7:0]            add_byte;
  logic [HashWidth-1:0]  add_val;
  logic [DigitWidth-1:0] digit_x10;
  logic [DigitWidth-1:0] digit_nxt;
  err_e                  term_err;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign term       = (char_code_i == CharNul);

  // low nibble of '0'..'9' is the digit value
  assign digit_x10 = DigitWidth'({digit_q, 3'b000}) + DigitWidth'({digit_q, 1'b0});
  assign digit_nxt = digit_x10 + DigitWidth'(char_code_i[3:0]);
  assign add_val   = fold_char(add_byte);

  always_comb begin
    term_err = err_q;
    if (err_q == ErrNone && phase_q != PhNormal) begin
      term_err = ErrEscape;
    end
  end

  always_comb begin
    hash_d   = hash_q;
    phase_d  = phase_q;
    digit_d  = digit_q;
    len_d    = len_q;
    err_d    = err_q;
    add_en   = 1'b0;
    add_byte = char_code_i;
    if (accept) begin
      if (term) begin
        hash_d  = '0;
        phase_d = PhNormal;
        digit_d = '0;
        len_d   = '0;
        err_d   = ErrNone;
      end else if (err_q == ErrNone) begin
        unique case (phase_q)
          PhNormal: begin
            if (char_code_i == CharDot) begin
              len_d = '0;
            end else if (char_code_i == CharBslash) begin
              phase_d = PhEsc;
            end else begin
              add_en = 1'b1;
            end
          end
          PhEsc: begin
            if (char_code_i == CharBslash || char_code_i == CharDot) begin
              phase_d = PhNormal;
              add_en  = 1'b1;
            end else if (is_digit(char_code_i)) begin
              digit_d = DigitWidth'(char_code_i[3:0]);
              phase_d = PhDig1;
            end else begin
              phase_d = PhNormal;
              err_d   = ErrEscape;
            end
          end
          PhDig1: begin
            if (is_digit(char_code_i)) begin
              digit_d = digit_nxt;
              phase_d = PhDig2;
            end else begin
              phase_d = PhNormal;
              err_d   = ErrEscape;
            end
          end
          PhDig2: begin
            phase_d = PhNormal;
            if (is_digit(char_code_i)) begin
              digit_d = '0;
              if (digit_nxt == '0 || digit_nxt > MaxByte) begin
                err_d = ErrEscape;
              end else begin
                add_en   = 1'b1;
                add_byte = digit_nxt[7:0];
              end
            end else begin
              err_d = ErrEscape;
            end
          end
          default: begin
            phase_d = PhNormal;
          end
        endcase
        if (add_en) begin
          // hash*31 = (hash << 5) - hash
          hash_d = {hash_q[HashWidth-6:0], 5'b00000} - hash_q + add_val;
          len_d  = len_q + LenWidth'(1);
          if (len_d >= LimitLen) begin
            err_d = ErrLong;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && term) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= '0;
      phase_q     <= PhNormal;
      digit_q     <= '0;
      len_q       <= '0;
      err_q       <= ErrNone;
      out_valid_q <= 1'b0;
    end else begin
      hash_q      <= hash_d;
      phase_q     <= phase_d;
      digit_q     <= digit_d;
      len_q       <= len_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && term) begin
      name_hash_q  <= (term_err == ErrNone) ? hash_q : '0;
      error_code_q <= term_err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign name_hash_o  = name_hash_q;
  assign error_code_o = error_code_q;

`ifndef SYNTHESIS
  a_err_zero_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o != ErrNone) |-> (name_hash_o == '0))
    else $error("nonzero hash reported with an error code");

  a_err_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_code_o != 2'd3))
    else $error("undefined error code reported");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && term) |=> (out_valid_o && phase_q == PhNormal && hash_q == '0
                          && len_q == '0 && err_q == ErrNone))
    else $error("terminator did not clear decode state");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q == ErrNone) |-> (len_q < LimitLen))
    else $error("label length reached limit without error");

  a_err_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ErrNone) |-> (phase_q == PhNormal))
    else $error("escape still pending after error latched");
`endif

endmodule

### sim/tb_escaped_dns_name_hash.sv
`timescale 1ns / 100ps
// Testbench for escaped_dns_name_hash: directed and random escaped names with
// a self-contained hash predictor and a scoreboard. Depends on ednh_pkg and the DUT.
module tb_escaped_dns_name_hash;
  import ednh_pkg::*;

  localparam int unsigned LabelLimit = LabelLimitDefault;
  localparam int StallLimit = 1000;

  typedef struct packed {
    logic [HashWidth-1:0] hash;
    err_e                 code;
  } name_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           char_code = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [HashWidth-1:0] name_hash;
  logic [1:0]           error_code;

  // predictor state
  logic [HashWidth-1:0]  acc_hash;
  phase_e                esc_phase;
  logic [DigitWidth-1:0] esc_digits;
  logic [LenWidth-1:0]   label_len;
  err_e                  first_err;

  name_result_t expected_names[$];
  int  mismatch_count = 0;
  int  words_sent = 0;
  int  quiet_cycles = 0;
  int  hold_request = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;

  escaped_dns_name_hash #(
    .LabelLimit(LabelLimit)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .char_code_i (char_code),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .name_hash_o (name_hash),
    .error_code_o(error_code)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic clear_name_state();
    acc_hash   = '0;
    esc_phase  = PhNormal;
    esc_digits = '0;
    label_len  = '0;
    first_err  = ErrNone;
  endtask

  // Case fold, sign extend, then hash = 31*hash + char.
  task automatic hash_label_char(input logic [7:0] c);
    logic [7:0] folded;
    folded = c;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      folded = c + 8'd32;
    end
    acc_hash  = acc_hash * 32'd31 + {{(HashWidth-8){folded[7]}}, folded};
    label_len = label_len + 1'b1;
    if (label_len >= LabelLimit) begin
      first_err = ErrLong;
    end
  endtask

  task automatic predict_name_word(input logic [7:0] c);
    name_result_t res;
    logic [31:0]  dec;
    bit           digit;
    digit = (c >= CharZero) && (c <= CharNine);
    if (c == CharNul) begin
      res.code = first_err;
      if (res.code == ErrNone && esc_phase != PhNormal) begin
        res.code = ErrEscape;
      end
      res.hash = (res.code == ErrNone) ? acc_hash : '0;
      expected_names.push_back(res);
      clear_name_state();
    end else if (first_err == ErrNone) begin
      case (esc_phase)
        PhNormal: begin
          if (c == CharDot) begin
            label_len = '0;
          end else if (c == CharBslash) begin
            esc_phase = PhEsc;
          end else begin
            hash_label_char(c);
          end
        end
        PhEsc: begin
          if (c == CharBslash || c == CharDot) begin
            esc_phase = PhNormal;
            hash_label_char(c);
          end else if (digit) begin
            esc_digits = DigitWidth'(c - CharZero);
            esc_phase  = PhDig1;
          end else begin
            esc_phase = PhNormal;
            first_err = ErrEscape;
          end
        end
        PhDig1: begin
          if (digit) begin
            esc_digits = DigitWidth'(esc_digits * 10) + DigitWidth'(c - CharZero);
            esc_phase  = PhDig2;
          end else begin
            esc_phase = PhNormal;
            first_err = ErrEscape;
          end
        end
        default: begin
          esc_phase = PhNormal;
          if (digit) begin
            dec        = 32'(esc_digits) * 10 + 32'(c - CharZero);
            esc_digits = '0;
            if (dec == 0 || dec > 255) begin
              first_err = ErrEscape;
            end else begin
              hash_label_char(dec[7:0]);
            end
          end else begin
            first_err = ErrEscape;
          end
        end
      endcase
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = send_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (!in_ready);
    predict_name_word(c);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  task automatic send_label(input int len);
    for (int i = 0; i < len; i++) begin
      send_char(((i % 3) == 0 ? CharUpperA : 8'h61) + 8'(i % 26));
    end
  endtask

  task automatic send_decimal_escape(input int v);
    send_char(CharBslash);
    send_char(CharZero + 8'((v / 100) % 10));
    send_char(CharZero + 8'((v / 10) % 10));
    send_char(CharZero + 8'(v % 10));
  endtask

  task automatic send_random_label_char();
    int   kind;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      c = ($urandom_range(0, 1) ? CharUpperA : 8'h61) + 8'($urandom_range(0, 25));
      send_char(c);
    end else if (kind < 50) begin
      c = 8'($urandom_range(8'h20, 8'h7E));
      if (c == CharBslash || c == CharDot) begin
        c = 8'h2D;
      end
      send_char(c);
    end else if (kind < 65) begin
      send_char(8'($urandom_range(8'h80, 8'hFF)));
    end else if (kind < 72) begin
      send_char(8'($urandom_range(8'h01, 8'h1F)));
    end else if (kind < 80) begin
      send_char(CharBslash);
      send_char($urandom_range(0, 1) ? CharBslash : CharDot);
    end else if (kind < 95) begin
      send_decimal_escape($urandom_range(1, 255));
    end else if (kind < 98) begin
      // broken escapes: bad follower, out of range value, short digit run
      case ($urandom_range(0, 2))
        0: begin
          send_char(CharBslash);
          send_char(8'($urandom_range(1, 255)));
        end
        1: send_decimal_escape($urandom_range(0, 1) ? 0 : $urandom_range(256, 999));
        default: begin
          send_char(CharBslash);
          send_char(CharZero + 8'($urandom_range(0, 9)));
          send_char(8'($urandom_range(1, 255)));
        end
      endcase
    end else begin
      send_char(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic send_random_name();
    int n_labels;
    int len;
    n_labels = $urandom_range(0, 4);
    for (int l = 0; l < n_labels; l++) begin
      if (l > 0 || $urandom_range(0, 9) == 0) begin
        send_char(CharDot);
      end
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(LabelLimit - 8, LabelLimit + 6)
                                         : $urandom_range(0, 8);
      for (int k = 0; k < len; k++) begin
        send_random_label_char();
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      send_char(CharDot);
    end
    send_char(CharNul);
  endtask

  task automatic test_plain_labels();
    send_char(CharNul);
    send_string(".Az..m-9_");
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(8'h01);
    send_char(CharDot);
    send_char(CharNul);
  endtask

  task automatic test_escapes();
    send_string("a\\\\b\\.c\\001\\255\\065");
    send_char(CharNul);
  endtask

  task automatic test_malformed_escapes();
    string bad[8];
    bad = '{"\\x", "\\1a", "\\12.", "\\000", "\\256", "\\", "\\12", "\\9"};
    foreach (bad[i]) begin
      send_string(bad[i]);
      send_char(CharNul);
    end
    // only the first error counts, the rest of the name is dropped
    send_string("\\q");
    send_label(LabelLimit + 2);
    send_char(CharNul);
  endtask

  task automatic test_long_labels();
    send_label(LabelLimit - 1);
    send_char(CharDot);
    send_label(LabelLimit - 1);
    send_char(CharNul);
    send_label(LabelLimit);
    send_char(CharNul);
    send_label(LabelLimit);
    send_string(".x\\q");
    send_char(CharNul);
    send_label(LabelLimit - 2);
    send_string("\\.\\");
    send_char(CharNul);
  endtask

  task automatic test_random_names();
    int stop_at;
    int n;
    stop_at = words_sent + 450;
    n = 0;
    while (words_sent < stop_at) begin
      if ((n % 8) == 0) begin
        {send_idle, recv_idle} = 2'($urandom_range(0, 3));
      end
      send_random_name();
      n++;
    end
  endtask

  // Receiver stops for a long stretch while short names keep coming.
  task automatic test_output_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_request = 300;
    for (int i = 0; i < 40; i++) begin
      send_string("ab");
      send_char(CharNul);
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    int   stall;
    name_result_t want;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = recv_idle ? $urandom_range(0, 11) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_names.size() == 0) begin
        $error("unexpected word: name_hash %h error_code %0d", name_hash, error_code);
        mismatch_count++;
      end else begin
        want = expected_names.pop_front();
        if (name_hash !== want.hash) begin
          $error("name_hash: expected %h, got %h", want.hash, name_hash);
          mismatch_count++;
        end
        if (error_code !== want.code) begin
          $error("error_code: expected %0d, got %0d", want.code, error_code);
          mismatch_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    clear_name_state();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_plain_labels();
    test_escapes();
    test_malformed_escapes();
    test_long_labels();
    test_random_names();
    test_output_backpressure();
    in_valid <= 1'b0;
    while (expected_names.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
